/* hdl/lpsd_pkg.sv */
// Package for the length-prefixed SPI LCD deframer.
// Holds the request, response and queue entry types and shared constants.
// No dependencies.
package lpsd_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] ECHO_HEADER  = 8'h00;
   localparam logic [7:0] ECHO_PAYLOAD = 8'hCC;
   localparam logic [2:0] BIT_LAST     = 3'd7;
   localparam logic [6:0] LEN_ZERO     = 7'd0;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       packet_start;
      logic       toggle_ok;
   } req_type;

   typedef struct packed {
      logic       spi_active;
      logic       mosi_bit;
      logic       dc_level;
      logic [2:0] bit_index;
      logic [7:0] echo_byte;
      logic       last;
   } rsp_type;

   // one classified byte handed from front to back
   typedef struct packed {
      logic       is_payload;
      logic       dc;
      logic [7:0] data;
   } job_type;

endpackage

/* hdl/length_prefixed_spi_lcd_deframer_top.sv */
// Top level of the length-prefixed SPI LCD deframer.
// Depends on lpsd_pkg, lpsd_front, lpsd_queue and lpsd_back.
//
// Received packet bytes come in on the req_ channel and are classified at once
// as header or payload by the front end, which keeps the remaining byte count
// and the data/command type; a byte with a bad toggle is taken and dropped.
// A queue of QUEUE_DEPTH entries feeds the back end, which issues one response
// per cycle while rsp_ready allows: a header gives one item, a payload byte eight
// serial bits, MSB first, from the back end's single bit-per-cycle serialiser;
// requests keep being taken while the queue has room. A request passes through
// a queue entry, the back end's job registers and its output register on the
// way to the response.
module length_prefixed_spi_lcd_deframer_top #(
   parameter int QUEUE_DEPTH = lpsd_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lpsd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lpsd_pkg::rsp_type rsp_payload
);

   logic              q_full, q_empty, q_push, q_pop;
   lpsd_pkg::job_type push_job, pop_job;

   lpsd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (push_job)
   );

   lpsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .pop_job  (pop_job)
   );

   lpsd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_job       (pop_job),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* hdl/lpsd_front.sv */
// Front end: accepts request bytes, tracks framing state, classifies each byte.
// Depends on lpsd_pkg.
module lpsd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lpsd_pkg::req_type req_payload,
   input  logic              q_full,
   output logic              q_push,
   output lpsd_pkg::job_type q_job
);

   logic [6:0] remaining_ff, remaining_in;
   logic       is_data_ff, is_data_in;
   logic [6:0] cnt_cur;
   logic       dc_cur;

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready && req_payload.toggle_ok;

   always_comb begin
      cnt_cur = req_payload.packet_start ? lpsd_pkg::LEN_ZERO : remaining_ff;
      dc_cur  = req_payload.packet_start ? 1'b0 : is_data_ff;
      q_job.data = req_payload.rx_byte;
      if (cnt_cur == lpsd_pkg::LEN_ZERO) begin
         // header: length in low bits, type in bit 7
         remaining_in     = req_payload.rx_byte[6:0];
         is_data_in       = req_payload.rx_byte[7];
         q_job.is_payload = 1'b0;
         q_job.dc         = req_payload.rx_byte[7];
      end else begin
         remaining_in     = cnt_cur - 7'd1;
         is_data_in       = dc_cur;
         q_job.is_payload = 1'b1;
         q_job.dc         = dc_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= lpsd_pkg::LEN_ZERO;
         is_data_ff   <= 1'b0;
      end else if (q_push) begin
         remaining_ff <= remaining_in;
         is_data_ff   <= is_data_in;
      end
   end

endmodule

/* hdl/lpsd_queue.sv */
// Short FIFO of classified bytes between front and back ends.
// Depends on lpsd_pkg.
module lpsd_queue #(
   parameter int DEPTH = lpsd_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lpsd_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output lpsd_pkg::job_type pop_job
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   lpsd_pkg::job_type mem [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign pop_job = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PW'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PW'(1);
      if (push && !pop) count_in = count_ff + CW'(1);
      else if (pop && !push) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_FULL)
      else $error("queue count beyond depth");
`endif

endmodule

/* hdl/lpsd_back.sv */
// Back end: turns queued bytes into response items, one per cycle unless rsp_ready stalls.
// Headers give one item, payload bytes eight serial bits. Depends on lpsd_pkg.
module lpsd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  lpsd_pkg::job_type q_job,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lpsd_pkg::rsp_type rsp_payload
);

   logic              busy_ff, busy_in;
   logic              payload_ff, payload_in;
   logic              dc_ff, dc_in;
   logic [7:0]        shift_ff, shift_in;
   logic [2:0]        idx_ff, idx_in;
   logic              out_valid_ff, out_valid_in;
   lpsd_pkg::rsp_type out_ff, out_in;
   logic              advance, item_last;

   assign advance   = busy_ff && (!out_valid_ff || rsp_ready);
   assign item_last = !payload_ff || (idx_ff == lpsd_pkg::BIT_LAST);
   assign q_pop     = !q_empty && (!busy_ff || (advance && item_last));

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   always_comb begin
      busy_in      = busy_ff;
      payload_in   = payload_ff;
      dc_in        = dc_ff;
      shift_in     = shift_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;

      if (advance) begin
         out_valid_in         = 1'b1;
         out_in.spi_active    = payload_ff;
         out_in.mosi_bit      = payload_ff & shift_ff[7];
         out_in.dc_level      = dc_ff;
         out_in.bit_index     = idx_ff;
         out_in.echo_byte     = payload_ff ? lpsd_pkg::ECHO_PAYLOAD : lpsd_pkg::ECHO_HEADER;
         out_in.last          = item_last;
         shift_in             = {shift_ff[6:0], 1'b0};
         idx_in               = idx_ff + 3'd1;
         if (item_last) busy_in = 1'b0;
      end

      if (q_pop) begin
         busy_in    = 1'b1;
         payload_in = q_job.is_payload;
         dc_in      = q_job.dc;
         shift_in   = q_job.data;
         idx_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
      payload_ff <= payload_in;
      dc_ff      <= dc_in;
      shift_ff   <= shift_in;
      out_ff     <= out_in;
   end

`ifndef SYNTHESIS
   a_header_single: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !payload_ff) |-> (idx_ff == 3'd0))
      else $error("header job past its only item");
   a_header_item: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.spi_active) |-> (out_ff.last && out_ff.bit_index == 3'd0))
      else $error("header response malformed");
   a_last_on_bit7: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.spi_active) |-> (out_ff.last == (out_ff.bit_index == 3'd7)))
      else $error("payload last flag misplaced");
`endif

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the length-prefixed SPI LCD deframer.
// Needs lpsd_pkg and length_prefixed_spi_lcd_deframer_top; predicts every
// response from the accepted requests and checks them in order.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Tracks the frame state and holds the responses still owed.
   class lcd_bit_scoreboard;
      logic [6:0]        bytes_left;
      logic              data_mode;
      lpsd_pkg::rsp_type owed_bits[$];
      int                error_count;

      function new();
         bytes_left  = lpsd_pkg::LEN_ZERO;
         data_mode   = 1'b0;
         error_count = 0;
      endfunction

      function void note_request(lpsd_pkg::req_type item);
         lpsd_pkg::rsp_type bit_rsp;
         if (!item.toggle_ok)
            return;
         if (item.packet_start) begin
            bytes_left = lpsd_pkg::LEN_ZERO;
            data_mode  = 1'b0;
         end
         if (bytes_left == lpsd_pkg::LEN_ZERO) begin
            bytes_left         = item.rx_byte[6:0];
            data_mode          = item.rx_byte[7];
            bit_rsp.spi_active = 1'b0;
            bit_rsp.mosi_bit   = 1'b0;
            bit_rsp.dc_level   = data_mode;
            bit_rsp.bit_index  = 3'd0;
            bit_rsp.echo_byte  = lpsd_pkg::ECHO_HEADER;
            bit_rsp.last       = 1'b1;
            owed_bits.push_back(bit_rsp);
            return;
         end
         for (int k = 0; k < 8; k++) begin
            bit_rsp.spi_active = 1'b1;
            bit_rsp.mosi_bit   = item.rx_byte[7 - k];
            bit_rsp.dc_level   = data_mode;
            bit_rsp.bit_index  = 3'(k);
            bit_rsp.echo_byte  = lpsd_pkg::ECHO_PAYLOAD;
            bit_rsp.last       = (3'(k) == lpsd_pkg::BIT_LAST);
            owed_bits.push_back(bit_rsp);
         end
         bytes_left = bytes_left - 7'd1;
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] MISMATCH: %s", $time, msg);
         error_count++;
      endtask

      task check_response(lpsd_pkg::rsp_type got);
         lpsd_pkg::rsp_type want;
         string             diffs;
         if (owed_bits.size() == 0) begin
            report_mismatch($sformatf("response %h with nothing owed", got));
            return;
         end
         want  = owed_bits.pop_front();
         diffs = "";
         if (got.spi_active !== want.spi_active)
            diffs = {diffs, $sformatf(" spi_active %b/%b", got.spi_active, want.spi_active)};
         if (got.mosi_bit !== want.mosi_bit)
            diffs = {diffs, $sformatf(" mosi_bit %b/%b", got.mosi_bit, want.mosi_bit)};
         if (got.dc_level !== want.dc_level)
            diffs = {diffs, $sformatf(" dc_level %b/%b", got.dc_level, want.dc_level)};
         if (got.bit_index !== want.bit_index)
            diffs = {diffs, $sformatf(" bit_index %0d/%0d", got.bit_index, want.bit_index)};
         if (got.echo_byte !== want.echo_byte)
            diffs = {diffs, $sformatf(" echo_byte %h/%h", got.echo_byte, want.echo_byte)};
         if (got.last !== want.last)
            diffs = {diffs, $sformatf(" last %b/%b", got.last, want.last)};
         if (diffs != "")
            report_mismatch({"response differs (got/exp):", diffs});
      endtask
   endclass

   logic              clock;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   lpsd_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   lpsd_pkg::rsp_type rsp_payload;

   lcd_bit_scoreboard ledger;
   int   good_sent    = 0;
   bit   random_phase = 1'b0;
   bit   steady_flow  = 1'b0;
   logic hold_rsp     = 1'b0;

   length_prefixed_spi_lcd_deframer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Offers one request, with random idle cycles ahead of it, and waits for it to be taken.
   task automatic send_request(input logic [7:0] data, input logic start, input logic ok);
      lpsd_pkg::req_type item;
      item.rx_byte      = data;
      item.packet_start = start;
      item.toggle_ok    = ok;
      while (!steady_flow && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      ledger.note_request(item);
      if (ok)
         good_sent++;
   endtask

   function automatic logic [7:0] random_header();
      int         pick;
      logic [6:0] len;
      logic       dc_sel;
      pick   = $urandom_range(99);
      dc_sel = 1'($urandom_range(1));
      if (pick < 65)
         len = 7'($urandom_range(4));
      else if (pick < 85)
         len = 7'($urandom_range(10, 5));
      else
         len = 7'($urandom_range(127));
      return {dc_sel, len};
   endfunction

   // One packet: a few frames, payload bytes with the odd bad-toggle byte mixed in,
   // sometimes cut short before the count runs out.
   task automatic send_packet();
      int         frames;
      int         n;
      logic [7:0] hdr;
      logic [6:0] len;
      frames = $urandom_range(3, 1);
      for (int f = 0; f < frames; f++) begin
         hdr = random_header();
         send_request(hdr, f == 0, 1'b1);
         len = hdr[6:0];
         n   = (len > 10) ? $urandom_range(10) : len;
         if ($urandom_range(99) < 12)
            n = $urandom_range(n);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 8)
               send_request(8'($urandom), 1'($urandom_range(1)), 1'b0);
            send_request(8'($urandom), 1'b0, 1'b1);
         end
         if (n < len)
            break;
      end
   endtask

   // Response side: checks at each edge, then picks ready for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         ledger.check_response(rsp_payload);
      if (reset || hold_rsp)
         rsp_ready <= 1'b0;
      else if (steady_flow)
         rsp_ready <= 1'b1;
      else
         rsp_ready <= ($urandom_range(99) >= 37);
   end

   // Long back-pressure stretch so the queue fills and requests stall.
   initial begin
      wait (random_phase && good_sent >= 20);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (250) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      ledger = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // zero-length command header: next byte is a header again
      send_request(8'h00, 1'b1, 1'b1);
      send_request(8'h82, 1'b0, 1'b1);
      send_request(8'hFF, 1'b0, 1'b1);
      send_request(8'h00, 1'b0, 1'b1);
      send_request(8'h01, 1'b0, 1'b1);
      send_request(8'hA5, 1'b0, 1'b1);
      // bad toggle is dropped even on a packet start
      send_request(8'h85, 1'b1, 1'b0);
      send_request(8'hFF, 1'b1, 1'b1);
      send_request(8'h5A, 1'b0, 1'b1);
      send_request(8'h80, 1'b0, 1'b1);
      send_request(8'h33, 1'b0, 1'b0);
      send_request(8'h01, 1'b0, 1'b1);
      // packet start mid-frame clears the count and type
      send_request(8'h7F, 1'b1, 1'b1);
      send_request(8'hC3, 1'b0, 1'b1);
      send_request(8'h80, 1'b1, 1'b1);
      send_request(8'h7E, 1'b0, 1'b1);
      send_request(8'hFE, 1'b0, 1'b1);
      send_request(8'h81, 1'b1, 1'b1);
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'h24, 1'b0, 1'b1);
      send_request(8'h03, 1'b0, 1'b1);

      good_sent    = 0;
      random_phase = 1'b1;
      while (good_sent < 135) begin
         steady_flow = (good_sent >= 60 && good_sent < 100);
         if ($urandom_range(99) < 12)
            send_request(8'($urandom), 1'($urandom_range(1)), $urandom_range(99) < 30);
         else
            send_packet();
      end
      steady_flow = 1'b0;
      req_valid <= 1'b0;

      while (ledger.owed_bits.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (ledger.error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

/* files.f */
hdl/lpsd_pkg.sv
hdl/lpsd_front.sv
hdl/lpsd_queue.sv
hdl/lpsd_back.sv
hdl/length_prefixed_spi_lcd_deframer_top.sv
tb/sv/testbench.sv
